@@ rtl/acas_pkg.sv @@
// ----------------------------------------------------------------------------
// acas_pkg: shared definitions for the channel average and scale block
// Widths used by all modules, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package acas_pkg;

  localparam int RAW_W          = 16;
  localparam int SAMPLE_SHIFT   = 3;
  localparam int SAMPLE_W       = RAW_W - SAMPLE_SHIFT;
  localparam int SUM_W          = 29;
  localparam int CNT_W          = 16;
  localparam int DATA_W         = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int DIFF_W         = SUM_W + 2;
  localparam int PROD_W         = DIFF_W + DATA_W;
  localparam int DIV_STEPS_W    = $clog2(SUM_W);
  localparam int INDEX_W        = 3;
  localparam int SCALE_STAGES   = 3;

  localparam logic [INDEX_W-1:0] REG_AVERAGE_COUNT    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_INVERT_SIGN      = 3'd1;
  localparam logic [INDEX_W-1:0] REG_OFFSET_VALUE     = 3'd2;
  localparam logic [INDEX_W-1:0] REG_GAIN_VALUE       = 3'd3;
  localparam logic [INDEX_W-1:0] REG_CHANGE_THRESHOLD = 3'd4;

  localparam logic signed [DATA_W-1:0] GAIN_RESET = 16'sd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                       start;
    logic [SUM_W-1:0]           value;
    logic                       invert;
    logic signed [DATA_W-1:0]   offset;
    logic signed [DATA_W-1:0]   gain;
  } scale_req_t;

endpackage

@@ rtl/acas_div.sv @@
// ----------------------------------------------------------------------------
// acas_div: serial unsigned divider
// Restoring division of the block sum by the sample count, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module acas_div
  import acas_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       dvs;
  logic [SUM_W-1:0]       quo;
  logic [DIV_STEPS_W-1:0] steps;
  logic                   busy;
  logic [CNT_W:0]         trial;
  logic                   fits;

  assign trial    = {rem, quo[SUM_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo   <= req.dividend;
      dvs   <= req.divisor;
      rem   <= '0;
      steps <= DIV_STEPS_W'(SUM_W - 1);
    end else if (busy) begin
      rem   <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
      quo   <= {quo[SUM_W-2:0], fits};
      steps <= steps - 1'b1;
    end
  end

endmodule

@@ rtl/acas_scale.sv @@
// ----------------------------------------------------------------------------
// acas_scale: offset correction and gain scaling
// Three stages: offset difference, signed product, truncation toward zero
// with saturation to the signed output range.
// ----------------------------------------------------------------------------
module acas_scale
  import acas_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  scale_req_t               req,
  output logic                     done,
  output logic signed [DATA_W-1:0] result
);

  logic [SCALE_STAGES-1:0]   vld;
  logic signed [DIFF_W-1:0]  val_ext;
  logic signed [DIFF_W-1:0]  off_ext;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DATA_W-1:0]  gain;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  quot;
  logic signed [PROD_W-1:0]  bias;

  assign val_ext = signed'({2'b00, req.value});
  assign off_ext = DIFF_W'(req.offset);
  assign bias    = prod[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC_BITS) - 1) : '0;
  assign quot    = (prod + bias) >>> GAIN_FRAC_BITS;
  assign done    = vld[SCALE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[SCALE_STAGES-2:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      diff <= req.invert ? off_ext - val_ext : val_ext - off_ext;
      gain <= req.gain;
    end
    prod <= diff * gain;
    if (quot > PROD_W'(32767)) begin
      result <= 16'sh7FFF;
    end else if (quot < -PROD_W'(32768)) begin
      result <= 16'sh8000;
    end else begin
      result <= quot[DATA_W-1:0];
    end
  end

endmodule

@@ rtl/adc_channel_average_scale.sv @@
// ----------------------------------------------------------------------------
// adc_channel_average_scale: one converter channel conditioner
// Averages, offset-corrects and gain-scales converter samples and flags
// large changes of the output.
// ----------------------------------------------------------------------------
// Each request returns exactly one result. With the channel unused or a block
// average still filling, the request passes from the idle state straight to
// the done state; a single sample first passes the three-stage scaling
// pipeline. A request that closes a block average goes through the serial
// divider, which produces one of the 29 quotient bits per cycle, and then the
// scaling pipeline. A finished result waits in the output register, so the
// next request can be taken while it is still outstanding.
module adc_channel_average_scale
  import acas_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write_enable,
  input  logic [INDEX_W-1:0]       write_index,
  input  logic [DATA_W-1:0]        write_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [RAW_W-1:0]         raw_result,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] scaled_value,
  output logic                     change_trigger
);

  logic [CNT_W-1:0]          average_count;
  logic                      invert_sign;
  logic signed [DATA_W-1:0]  offset_value;
  logic signed [DATA_W-1:0]  gain_value;
  logic [DATA_W-1:0]         change_threshold;

  logic [SUM_W-1:0]          sample_sum;
  logic [CNT_W-1:0]          sample_counter;
  logic signed [DATA_W-1:0]  last_output;
  logic signed [DATA_W-1:0]  x_val;

  state_t                    state;
  state_t                    state_next;

  logic [SAMPLE_W-1:0]       sample;
  logic [SUM_W-1:0]          sum_inc;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      accept;
  logic                      mode_unused;
  logic                      mode_single;
  logic                      block_close;
  logic                      out_load;
  logic signed [DATA_W:0]    change;
  logic [DATA_W:0]           change_mag;

  div_req_t                  div_req;
  logic                      div_done;
  logic [SUM_W-1:0]          div_quotient;
  scale_req_t                scale_req;
  logic                      scale_done;
  logic signed [DATA_W-1:0]  scale_result;

  assign sample      = raw_result[RAW_W-1:SAMPLE_SHIFT];
  assign sum_inc     = sample_sum + SUM_W'(sample);
  assign cnt_inc     = sample_counter + 1'b1;
  assign mode_unused = average_count == '0;
  assign mode_single = average_count == CNT_W'(1);
  assign block_close = cnt_inc >= average_count;
  assign accept      = in_valid && in_ready;
  assign change      = (DATA_W + 1)'(x_val) - (DATA_W + 1)'(last_output);
  assign change_mag  = change[DATA_W] ? (DATA_W + 1)'(-change) : change;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode_unused) begin
            state_next = ST_DONE;
          end else if (mode_single) begin
            state_next = ST_SCALE;
          end else if (block_close) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready           = 1'b0;
    out_load           = 1'b0;
    div_req.start      = 1'b0;
    div_req.dividend   = sum_inc;
    div_req.divisor    = (cnt_inc == '0) ? CNT_W'(1) : cnt_inc;
    scale_req.start    = 1'b0;
    scale_req.value    = div_quotient;
    scale_req.invert   = invert_sign;
    scale_req.offset   = offset_value;
    scale_req.gain     = gain_value;
    case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        scale_req.value = SUM_W'(sample);
        if (in_valid && !mode_unused) begin
          scale_req.start = mode_single;
          div_req.start   = !mode_single && block_close;
        end
      end
      ST_DIV: begin
        scale_req.start = div_done;
      end
      ST_SCALE: begin
      end
      ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_count    <= '0;
      invert_sign      <= 1'b0;
      offset_value     <= '0;
      gain_value       <= GAIN_RESET;
      change_threshold <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_AVERAGE_COUNT:    average_count    <= write_data;
        REG_INVERT_SIGN:      invert_sign      <= write_data[0];
        REG_OFFSET_VALUE:     offset_value     <= signed'(write_data);
        REG_GAIN_VALUE:       gain_value       <= signed'(write_data);
        REG_CHANGE_THRESHOLD: change_threshold <= write_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sample_sum     <= '0;
      sample_counter <= '0;
      last_output    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && !mode_unused && !mode_single) begin
        sample_sum     <= block_close ? '0 : sum_inc;
        sample_counter <= block_close ? '0 : cnt_inc;
      end
      if (out_load) begin
        last_output <= x_val;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_val <= mode_unused ? '0 : last_output;
    end else if (state == ST_SCALE && scale_done) begin
      x_val <= scale_result;
    end
    if (out_load) begin
      scaled_value   <= x_val;
      change_trigger <= (change_threshold != '0) && (change_mag > {1'b0, change_threshold});
    end
  end

  acas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  acas_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .req    (scale_req),
    .done   (scale_done),
    .result (scale_result)
  );

endmodule

@@ bench/adc_channel_average_scale_test.sv @@
// ----------------------------------------------------------------------------
// adc_channel_average_scale_test: self-checking bench for the channel block
// Raw converter words are offered as requests under random idling on both
// sides. A behavioural copy of the averaging, offset and gain arithmetic
// predicts each output, which is compared field by field as it arrives.
// Settings change between phases, only once the block has gone quiet.
// ----------------------------------------------------------------------------
module adc_channel_average_scale_test;
  import acas_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 50;
  localparam int RANDOM_REQUESTS = 900;
  localparam int STEADY_FROM     = 750;
  localparam longint VALUE_MAX   = 2 ** (DATA_W - 1) - 1;
  localparam longint VALUE_MIN   = -(2 ** (DATA_W - 1));

  typedef struct packed {
    logic signed [DATA_W-1:0] scaled;
    logic                     trigger;
  } channel_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     write_enable = 1'b0;
  logic [INDEX_W-1:0]       write_index = REG_AVERAGE_COUNT;
  logic [DATA_W-1:0]        write_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [RAW_W-1:0]         raw_result = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] scaled_value;
  logic                     change_trigger;

  // Shadow copy of the block's settings and running state.
  logic [CNT_W-1:0]         avg_count = '0;
  logic                     invert = 1'b0;
  logic signed [DATA_W-1:0] offset = '0;
  logic signed [DATA_W-1:0] gain = GAIN_RESET;
  logic [DATA_W-1:0]        threshold = '0;
  logic [SUM_W-1:0]         block_sum = '0;
  logic [CNT_W-1:0]         block_count = '0;
  logic signed [DATA_W-1:0] previous_value = '0;

  logic [RAW_W-1:0]  raw_requests[$];
  channel_result_t   expected_outputs[$];
  int                failures = 0;
  int                stall_odds = 0;
  int                send_gap = 0;
  int                recv_gap = 0;
  int                hold_left = 0;
  int                hold_asks = 0;
  int                hold_served = 0;
  int                quiet_cycles = 0;

  adc_channel_average_scale dut (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_data     (write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .raw_result     (raw_result),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scaled_value   (scaled_value),
    .change_trigger (change_trigger)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [DATA_W-1:0] apply_gain(longint value);
    longint corrected;
    longint product;
    longint quotient;
    corrected = invert ? longint'(offset) - value : value - longint'(offset);
    product = corrected * longint'(gain);
    quotient = product / (longint'(1) << GAIN_FRAC_BITS);
    if (quotient > VALUE_MAX) quotient = VALUE_MAX;
    if (quotient < VALUE_MIN) quotient = VALUE_MIN;
    return quotient[DATA_W-1:0];
  endfunction

  function automatic channel_result_t condition_sample(logic [RAW_W-1:0] raw);
    logic [SAMPLE_W-1:0]      sample;
    logic [CNT_W-1:0]         divisor;
    logic [SUM_W-1:0]         mean;
    logic signed [DATA_W-1:0] value;
    int                       change;
    channel_result_t          result;
    sample = raw[RAW_W-1:SAMPLE_SHIFT];
    if (avg_count == 0) begin
      value = '0;
    end else if (avg_count == 1) begin
      value = apply_gain(longint'(sample));
    end else begin
      block_sum = block_sum + sample;
      block_count = block_count + 1'b1;
      if (block_count >= avg_count) begin
        divisor = block_count;
        if (divisor == 0) divisor = CNT_W'(1);
        mean = block_sum / divisor;
        value = apply_gain(longint'(mean));
        block_sum = '0;
        block_count = '0;
      end else begin
        value = previous_value;
      end
    end
    change = int'(value) - int'(previous_value);
    if (change < 0) change = -change;
    result.scaled = value;
    result.trigger = (threshold != 0) && (change > int'(threshold));
    previous_value = value;
    return result;
  endfunction

  // Sender: offers queued raw words and predicts each accepted request.
  always @(posedge clk) begin
    logic             valid_next;
    logic [RAW_W-1:0] data_next;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_outputs.push_back(condition_sample(raw_result));
      end
      valid_next = in_valid && !in_ready;
      data_next = raw_result;
      if (!valid_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (raw_requests.size() > 0) begin
          data_next = raw_requests.pop_front();
          valid_next = 1'b1;
          if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            send_gap = $urandom_range(1, 7);
          end
        end
      end
      in_valid <= valid_next;
      raw_result <= data_next;
    end
  end

  // Receiver: checks each accepted output and throttles out_ready.
  always @(posedge clk) begin
    channel_result_t wanted;
    logic            ready_next;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected output: scaled_value %0d, change_trigger %0b",
                 scaled_value, change_trigger);
          failures++;
        end else begin
          wanted = expected_outputs.pop_front();
          if (scaled_value !== wanted.scaled) begin
            $error("scaled_value: expected %0d, actual %0d",
                   $signed(wanted.scaled), scaled_value);
            failures++;
          end
          if (change_trigger !== wanted.trigger) begin
            $error("change_trigger: expected %0b, actual %0b",
                   wanted.trigger, change_trigger);
            failures++;
          end
        end
      end
      ready_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_served != hold_asks) begin
        hold_served++;
        hold_left = HOLD_OFF_CYCLES;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else begin
        ready_next = 1'b1;
        if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
          recv_gap = $urandom_range(1, 7);
        end
      end
      out_ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(logic [INDEX_W-1:0] index, logic [DATA_W-1:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= index;
    write_data <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    case (index)
      REG_AVERAGE_COUNT:    avg_count = data;
      REG_INVERT_SIGN:      invert = data[0];
      REG_OFFSET_VALUE:     offset = data;
      REG_GAIN_VALUE:       gain = data;
      REG_CHANGE_THRESHOLD: threshold = data;
      default: ;
    endcase
  endtask

  task automatic set_channel(logic [DATA_W-1:0] count, logic [DATA_W-1:0] sign,
                             logic [DATA_W-1:0] offs, logic [DATA_W-1:0] gn,
                             logic [DATA_W-1:0] limit);
    write_register(REG_AVERAGE_COUNT, count);
    write_register(REG_INVERT_SIGN, sign);
    write_register(REG_OFFSET_VALUE, offs);
    write_register(REG_GAIN_VALUE, gn);
    write_register(REG_CHANGE_THRESHOLD, limit);
  endtask

  // Sampled on the falling edge, once the sender's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (raw_requests.size() != 0 || in_valid || expected_outputs.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int               queued;
    int               phase;
    int               phase_items;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] offs;
    logic [DATA_W-1:0] gn;
    logic [DATA_W-1:0] limit;
    queued = 0;
    phase = 0;
    stall_odds = 4;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Settings straight out of reset: channel unused.
    raw_requests.push_back(16'hFFFF);
    raw_requests.push_back(16'h0000);
    wait_drained();

    // Single samples with the reset gain of one.
    write_register(REG_AVERAGE_COUNT, 16'd1);
    raw_requests.push_back(16'hFFFF);
    raw_requests.push_back(16'h0007);
    raw_requests.push_back(16'h8000);
    raw_requests.push_back(16'h7FFF);
    wait_drained();

    // Writes to unused indexes must leave every setting alone.
    for (int i = REG_CHANGE_THRESHOLD + 1; i < 2 ** INDEX_W; i++) begin
      write_register(INDEX_W'(i), 16'($urandom));
    end
    raw_requests.push_back(16'h1238);
    wait_drained();

    // Saturation both ways, with and without inversion; spare sign bits ignored.
    set_channel(16'd1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1);
    raw_requests.push_back(16'hFFF8);
    raw_requests.push_back(16'h0000);
    wait_drained();
    set_channel(16'd1, 16'hFFFE, 16'h8000, 16'h8000, 16'hFFFF);
    raw_requests.push_back(16'hFFFF);
    raw_requests.push_back(16'h0008);
    wait_drained();
    set_channel(16'd1, 16'd0, 16'h8000, 16'h7FFF, 16'd100);
    raw_requests.push_back(16'h1234);
    wait_drained();
    set_channel(16'd1, 16'd1, 16'h7FFF, 16'h0100, 16'd0);
    raw_requests.push_back(16'h0000);
    raw_requests.push_back(16'hFFFF);
    wait_drained();

    // Block average of three, then a count raised and later lowered in the middle of a block.
    set_channel(16'd3, 16'd0, 16'd0, 16'h0100, 16'd50);
    raw_requests.push_back(16'hFFFF);
    raw_requests.push_back(16'h0000);
    raw_requests.push_back(16'h0010);
    raw_requests.push_back(16'hFFF8);
    wait_drained();
    write_register(REG_AVERAGE_COUNT, 16'hFFFF);
    raw_requests.push_back(16'hAAAA);
    raw_requests.push_back(16'h5555);
    wait_drained();
    write_register(REG_AVERAGE_COUNT, 16'd2);
    raw_requests.push_back(16'h4321);
    wait_drained();
    write_register(REG_AVERAGE_COUNT, 16'd0);
    raw_requests.push_back(16'hFFFF);
    wait_drained();

    while (queued < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0:       count = 16'd0;
        1, 2:    count = 16'd1;
        3:       count = 16'($urandom_range(9, 40));
        default: count = 16'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 4))
        0:       offs = 16'($urandom);
        1:       offs = 16'h8000;
        2:       offs = 16'h7FFF;
        default: offs = 16'($urandom_range(0, 200) - 100);
      endcase
      case ($urandom_range(0, 6))
        0:       gn = 16'($urandom);
        1:       gn = 16'h8000;
        2:       gn = 16'h7FFF;
        3:       gn = 16'd0;
        default: gn = 16'($urandom_range(0, 1024) - 512);
      endcase
      case ($urandom_range(0, 4))
        0:       limit = 16'd0;
        1:       limit = 16'hFFFF;
        2:       limit = 16'($urandom);
        default: limit = 16'($urandom_range(1, 300));
      endcase
      set_channel(count, 16'($urandom), offs, gn, limit);
      if ($urandom_range(0, 3) == 0) begin
        write_register(INDEX_W'($urandom_range(REG_CHANGE_THRESHOLD + 1, 2 ** INDEX_W - 1)),
                       16'($urandom));
      end
      if (queued >= STEADY_FROM) begin
        stall_odds = 0;
      end else begin
        case (phase % 3)
          0:       stall_odds = 3;
          1:       stall_odds = 8;
          default: stall_odds = 0;
        endcase
      end
      if (phase == 2) begin
        // Receiver stops for a long stretch while requests keep coming.
        hold_asks++;
      end
      phase_items = $urandom_range(20, 60);
      repeat (phase_items) begin
        case ($urandom_range(0, 9))
          0:       raw_requests.push_back(16'hFFFF);
          1:       raw_requests.push_back(16'h0000);
          default: raw_requests.push_back(16'($urandom));
        endcase
      end
      queued += phase_items;
      phase++;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && expected_outputs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/acas_pkg.sv
rtl/acas_div.sv
rtl/acas_scale.sv
rtl/adc_channel_average_scale.sv
bench/adc_channel_average_scale_test.sv
